// File: hw/rtl/hashed_result_cache_store_probe_defines.svh
// Assertion macros used by the checker of the result cache
`ifndef HASHED_RESULT_CACHE_STORE_PROBE_DEFINES_SVH
`define HASHED_RESULT_CACHE_STORE_PROBE_DEFINES_SVH

// Same-cycle implication, idle while reset is high
`define HRC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("result cache check failed");

// Next-cycle implication, also checked across reset
`define HRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("result cache check failed");

`endif

// File: hw/rtl/hrc_pkg.sv
// Shared types, constants and helpers for the result cache
package hrc_pkg;

  // table depth, a power of two
  localparam int TABLE_ENTRIES = 65536;
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int FOLD_SHIFT    = 32;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int  PADDR_W = 3;
  localparam logic REG_GEN = 1'b0;

  localparam logic [1:0] KIND_EXACT = 2'd0;
  localparam logic [1:0] KIND_UPPER = 2'd1;
  localparam logic [1:0] KIND_LOWER = 2'd2;

  typedef enum logic [1:0] {
    OP_STORE = 2'd0,
    OP_PROBE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [SLOT_W-1:0]  slot;
    logic [63:0]        key;
    logic signed [15:0] score;
    logic signed [7:0]  depth;
    logic [1:0]         kind;
    logic [15:0]        move;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
  } cmd_t;

  // one table line: tag above the packed entry word
  typedef struct packed {
    logic [63:0]        tag;
    logic [7:0]         gen;
    logic [15:0]        move;
    logic [1:0]         kind;
    logic signed [7:0]  depth;
    logic signed [15:0] score;
  } line_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic init;
    logic gen_clr;
  } be_stat_t;

  function automatic logic [SLOT_W-1:0] fold_slot(input logic [63:0] key);
    logic [63:0] f;
    f = key ^ (key >> FOLD_SHIFT);
    return f[SLOT_W-1:0];
  endfunction

endpackage

// File: hw/rtl/hrc_queue.sv
// Short command queue between the front and the table engine
module hrc_queue import hrc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cmd_t    push_data,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t stat
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head       = slots[rd_ptr];
  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);

endmodule

// File: hw/rtl/hrc_front.sv
// Command front: accept handshake, decode and slot fold into the queue
module hrc_front import hrc_pkg::*; (
  input  logic               start,
  input  logic [1:0]         command,
  input  logic [63:0]        key,
  input  logic signed [15:0] score_in,
  input  logic signed [7:0]  search_depth,
  input  logic [1:0]         bound_kind,
  input  logic [15:0]        move_in,
  input  logic signed [15:0] alpha_bound,
  input  logic signed [15:0] beta_bound,
  input  q_stat_t            q_stat,
  input  be_stat_t           be_stat,
  output logic               busy,
  output logic               push,
  output cmd_t               push_data
);

  // hold off while the queue is full or the power-up sweep runs
  assign busy = q_stat.full | be_stat.init;
  assign push = start & ~busy;

  always_comb begin
    push_data.op    = op_t'(command);
    push_data.slot  = fold_slot(key);
    push_data.key   = key;
    push_data.score = score_in;
    push_data.depth = search_depth;
    push_data.kind  = bound_kind;
    push_data.move  = move_in;
    push_data.alpha = alpha_bound;
    push_data.beta  = beta_bound;
  end

endmodule

// File: hw/rtl/hrc_back.sv
// Table engine: line memory, read-modify-write per command, clear sweeps
module hrc_back import hrc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         gen,
  input  q_stat_t            q_stat,
  input  cmd_t               head,
  output logic               pop,
  output be_stat_t           stat,
  output logic               done,
  output logic               key_found,
  output logic               score_usable,
  output logic signed [15:0] score_out,
  output logic [15:0]        move_out
);

  typedef enum logic [1:0] {S_INIT, S_IDLE, S_EXEC, S_CLEAR} state_t;

  state_t            state;
  logic [SLOT_W-1:0] cnt;
  logic              gen_clr;
  cmd_t              cur;

  line_t             mem [TABLE_ENTRIES];
  line_t             mem_rdata;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  line_t             mem_wdata;

  logic              last;
  logic              same;
  logic              replace;
  logic              usable;
  logic [15:0]       new_move;

  assign pop  = (state == S_IDLE) & ~q_stat.empty;
  assign last = (cnt == SLOT_W'(TABLE_ENTRIES - 1));

  always_comb begin
    same    = (mem_rdata.tag == cur.key);
    replace = ~same || (mem_rdata.gen != gen) ||
              ($signed(cur.depth) >= $signed(mem_rdata.depth));
    // keep the old move only on a tag match with no new move
    if (cur.move != '0) begin
      new_move = cur.move;
    end else if (same) begin
      new_move = mem_rdata.move;
    end else begin
      new_move = '0;
    end
    usable = ($signed(mem_rdata.depth) >= $signed(cur.depth)) &&
             ((mem_rdata.kind == KIND_EXACT) ||
              ((mem_rdata.kind == KIND_UPPER) &&
               ($signed(mem_rdata.score) <= $signed(cur.alpha))) ||
              ((mem_rdata.kind == KIND_LOWER) &&
               ($signed(mem_rdata.score) >= $signed(cur.beta))));
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt;
    mem_wdata = '0;
    case (state)
      S_INIT, S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_EXEC: begin
        mem_we          = (cur.op == OP_STORE) && replace;
        mem_waddr       = cur.slot;
        mem_wdata.tag   = cur.key;
        mem_wdata.gen   = gen;
        mem_wdata.move  = new_move;
        mem_wdata.kind  = cur.kind;
        mem_wdata.depth = cur.depth;
        mem_wdata.score = cur.score;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      mem_rdata <= mem[head.slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      cnt          <= '0;
      gen_clr      <= 1'b0;
      done         <= 1'b0;
      key_found    <= 1'b0;
      score_usable <= 1'b0;
      score_out    <= '0;
      move_out     <= '0;
    end else begin
      gen_clr      <= 1'b0;
      done         <= 1'b0;
      key_found    <= 1'b0;
      score_usable <= 1'b0;
      score_out    <= '0;
      move_out     <= '0;
      case (state)
        S_INIT: begin
          cnt <= cnt + 1'b1;
          if (last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            cur   <= head;
            cnt   <= '0;
            state <= (head.op == OP_CLEAR) ? S_CLEAR : S_EXEC;
          end
        end
        S_EXEC: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if ((cur.op == OP_PROBE) && same) begin
            key_found <= 1'b1;
            move_out  <= mem_rdata.move;
            if (usable) begin
              score_usable <= 1'b1;
              score_out    <= mem_rdata.score;
            end
          end
        end
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (last) begin
            done    <= 1'b1;
            gen_clr <= 1'b1;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign stat.init    = (state == S_INIT);
  assign stat.gen_clr = gen_clr;

endmodule

// File: hw/rtl/hashed_result_cache_store_probe.sv
// Top level of the direct-mapped result cache with its register port
//
// Commands enter on start when busy is low: store, probe, clear, or the
// unused code which does nothing. Every command gives exactly one result
// beat, shown for one cycle with done high; it cannot be held off. Store,
// clear and no-op beats carry all-zero fields.
// A store or probe is a read-modify-write of one table line: the engine pops
// it while idle and reads the line, then compares, writes and raises done; it
// takes no new command until that one is done (read, then compare and write).
// A two-entry queue sits between the accept logic and the engine, so start
// may be pulsed back to back; busy rises while the queue is full.
// Clear writes one line per cycle over all TABLE_ENTRIES lines, then gives
// its beat and zeroes the generation register.
// Reset: the generation register goes to zero and the engine sweeps the
// whole table to zero, all TABLE_ENTRIES (65536) lines, with busy high.
// The APB port holds one register, current_generation, at addresses 0-3; write
// it only while no command is outstanding.
module hashed_result_cache_store_probe import hrc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command,
  input  logic [63:0]        key,
  input  logic signed [15:0] score_in,
  input  logic signed [7:0]  search_depth,
  input  logic [1:0]         bound_kind,
  input  logic [15:0]        move_in,
  input  logic signed [15:0] alpha_bound,
  input  logic signed [15:0] beta_bound,
  output logic               done,
  output logic               key_found,
  output logic               score_usable,
  output logic signed [15:0] score_out,
  output logic [15:0]        move_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic     [7:0] gen;
  logic           push;
  logic           pop;
  cmd_t           push_data;
  cmd_t           head;
  q_stat_t        q_stat;
  be_stat_t       be_stat;
  logic           reg_wr;

  assign pready = 1'b1;
  assign reg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_GEN);
  assign prdata = (paddr[2] == REG_GEN) ? {24'd0, gen} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gen <= '0;
    end else if (reg_wr) begin
      gen <= pwdata[7:0];
    end else if (be_stat.gen_clr) begin
      gen <= '0;
    end
  end

  hrc_front u_front (
    .start        (start),
    .command      (command),
    .key          (key),
    .score_in     (score_in),
    .search_depth (search_depth),
    .bound_kind   (bound_kind),
    .move_in      (move_in),
    .alpha_bound  (alpha_bound),
    .beta_bound   (beta_bound),
    .q_stat       (q_stat),
    .be_stat      (be_stat),
    .busy         (busy),
    .push         (push),
    .push_data    (push_data)
  );

  hrc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  hrc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .gen          (gen),
    .q_stat       (q_stat),
    .head         (head),
    .pop          (pop),
    .stat         (be_stat),
    .done         (done),
    .key_found    (key_found),
    .score_usable (score_usable),
    .score_out    (score_out),
    .move_out     (move_out)
  );

endmodule

// File: hw/rtl/hrc_checker.sv
// Port-level checker for the result cache and its bind
`include "hashed_result_cache_store_probe_defines.svh"

module hrc_checker (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        done,
  input logic        key_found,
  input logic        score_usable,
  input logic [15:0] score_out,
  input logic [15:0] move_out
);

  logic miss_fields_zero;

  assign miss_fields_zero = (move_out == 16'd0) && !score_usable && (score_out == 16'd0);

  // power-up sweep keeps the block closed
  `HRC_ASSERT_NEXT(a_busy_after_rst, rst, busy)
  // the engine never gives two beats in a row
  `HRC_ASSERT_NEXT(a_no_back_to_back, done, !done)
  `HRC_ASSERT_IMP(a_usable_needs_hit, done && score_usable, key_found)
  `HRC_ASSERT_IMP(a_miss_is_zero, done && !key_found, miss_fields_zero)

endmodule

bind hashed_result_cache_store_probe hrc_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .done         (done),
  .key_found    (key_found),
  .score_usable (score_usable),
  .score_out    (score_out),
  .move_out     (move_out)
);
